>>> rtl/bdhq_pkg.sv
// shared types, constants and register map for the button debounce and head id qualifier
package bdhq_pkg;

    localparam int BUTTONS        = 4;
    localparam int BTN_OUT_W      = 4;
    localparam int STABLE_SAMPLES = 4;
    localparam int ADC_BITS       = 12;

    localparam int TICK_W = 16;
    localparam int CNT_W  = $clog2(STABLE_SAMPLES + 1);
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;

    localparam logic [TICK_W-1:0] AGE_MAX = {TICK_W{1'b1}};

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE      = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_IVL    = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_TRACER_LOW    = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_TRACER_HIGH   = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] CFG_CUTTER_LOW    = CFG_IDX_W'(4);
    localparam logic [CFG_IDX_W-1:0] CFG_CUTTER_HIGH   = CFG_IDX_W'(5);
    localparam logic [CFG_IDX_W-1:0] CFG_ABSENT_LOW    = CFG_IDX_W'(6);
    localparam logic [CFG_IDX_W-1:0] CFG_ASSUME_CUTTER = CFG_IDX_W'(7);

    // register reset values
    localparam logic [TICK_W-1:0]   RST_DEBOUNCE    = TICK_W'(50);
    localparam logic [TICK_W-1:0]   RST_SAMPLE_IVL  = TICK_W'(20);
    localparam logic [ADC_BITS-1:0] RST_TRACER_LOW  = ADC_BITS'(1800);
    localparam logic [ADC_BITS-1:0] RST_TRACER_HIGH = ADC_BITS'(2300);
    localparam logic [ADC_BITS-1:0] RST_CUTTER_LOW  = ADC_BITS'(200);
    localparam logic [ADC_BITS-1:0] RST_CUTTER_HIGH = ADC_BITS'(1500);
    localparam logic [ADC_BITS-1:0] RST_ABSENT_LOW  = ADC_BITS'(3800);

    typedef enum logic [1:0] {
        HEAD_UNKNOWN = 2'd0,
        HEAD_CUTTING = 2'd1,
        HEAD_TRACING = 2'd2,
        HEAD_ABSENT  = 2'd3
    } t_head;

    typedef struct packed {
        logic [ADC_BITS-1:0] tracer_low;
        logic [ADC_BITS-1:0] tracer_high;
        logic [ADC_BITS-1:0] cutter_low;
        logic [ADC_BITS-1:0] cutter_high;
        logic [ADC_BITS-1:0] absent_low;
        logic                assume_cutter;
        logic [TICK_W-1:0]   sample_interval;
    } t_head_cfg;

    typedef struct packed {
        t_head head_type;
        logic  head_known;
        logic  head_changed;
        logic  head_sampled;
    } t_head_res;

    typedef struct packed {
        logic [BTN_OUT_W-1:0] stable_buttons;
        logic [BTN_OUT_W-1:0] button_changed;
        t_head_res            head;
    } t_result;

endpackage

>>> rtl/bdhq_lane.sv
// one button debouncer lane: age counter, last raw level and stable level
module bdhq_lane (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_fire,
    input  logic                         i_raw,
    input  logic [bdhq_pkg::TICK_W-1:0]  i_debounce,
    output logic                         o_stable,
    output logic                         o_changed
);

    logic                        r_last;
    logic                        r_stable;
    logic [bdhq_pkg::TICK_W-1:0] r_age;
    logic                        n_last;
    logic                        n_stable;
    logic [bdhq_pkg::TICK_W-1:0] n_age;

    always_comb begin
        n_last = i_raw;
        if (i_raw != r_last) begin
            n_age = '0;
        end else if (r_age != bdhq_pkg::AGE_MAX) begin
            n_age = r_age + 1'b1;
        end else begin
            n_age = r_age;
        end
        o_changed = (i_raw != r_stable) && (n_age >= i_debounce);
        n_stable  = o_changed ? i_raw : r_stable;
        o_stable  = n_stable;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last   <= 1'b1;
            r_stable <= 1'b1;
            r_age    <= '0;
        end else if (i_fire) begin
            r_last   <= n_last;
            r_stable <= n_stable;
            r_age    <= n_age;
        end
    end

endmodule

>>> rtl/bdhq_head.sv
// head identification: sample timer, window classifier and consecutive-sample qualifier
module bdhq_head (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_fire,
    input  logic [bdhq_pkg::ADC_BITS-1:0]   i_adc,
    input  bdhq_pkg::t_head_cfg             i_cfg,
    output bdhq_pkg::t_head_res             o_res
);

    logic [bdhq_pkg::TICK_W-1:0] r_countdown;
    logic [bdhq_pkg::TICK_W-1:0] n_countdown;
    bdhq_pkg::t_head             r_cand;
    bdhq_pkg::t_head             n_cand;
    logic [bdhq_pkg::CNT_W-1:0]  r_count;
    logic [bdhq_pkg::CNT_W-1:0]  n_count;
    bdhq_pkg::t_head             r_stable;
    bdhq_pkg::t_head             n_stable;
    logic                        r_valid;
    logic                        n_valid;
    bdhq_pkg::t_head             w_class;
    logic                        w_sample;
    logic                        w_set;

    // fixed priority window compares
    always_comb begin
        if (i_adc >= i_cfg.tracer_low && i_adc <= i_cfg.tracer_high) begin
            w_class = bdhq_pkg::HEAD_TRACING;
        end else if (i_cfg.assume_cutter) begin
            w_class = bdhq_pkg::HEAD_CUTTING;
        end else if (i_adc >= i_cfg.absent_low) begin
            w_class = bdhq_pkg::HEAD_ABSENT;
        end else if (i_adc >= i_cfg.cutter_low && i_adc <= i_cfg.cutter_high) begin
            w_class = bdhq_pkg::HEAD_CUTTING;
        end else begin
            w_class = bdhq_pkg::HEAD_UNKNOWN;
        end
    end

    always_comb begin
        w_sample    = (r_countdown == '0);
        n_countdown = r_countdown - 1'b1;
        n_cand      = r_cand;
        n_count     = r_count;
        n_stable    = r_stable;
        n_valid     = r_valid;
        w_set       = 1'b0;
        if (w_sample) begin
            n_countdown = (i_cfg.sample_interval != '0) ? i_cfg.sample_interval - 1'b1 : '0;
            if (w_class == r_cand) begin
                if (r_count < bdhq_pkg::CNT_W'(bdhq_pkg::STABLE_SAMPLES)) begin
                    n_count = r_count + 1'b1;
                end
            end else begin
                n_cand  = w_class;
                n_count = bdhq_pkg::CNT_W'(1);
            end
            if (n_count >= bdhq_pkg::CNT_W'(bdhq_pkg::STABLE_SAMPLES)
                && (!r_valid || n_cand != r_stable)) begin
                w_set    = 1'b1;
                n_stable = n_cand;
                n_valid  = 1'b1;
            end
        end
        o_res.head_type    = n_stable;
        o_res.head_known   = n_valid;
        o_res.head_changed = w_set;
        o_res.head_sampled = w_sample;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_countdown <= '0;
            r_cand      <= bdhq_pkg::HEAD_UNKNOWN;
            r_count     <= '0;
            r_stable    <= bdhq_pkg::HEAD_UNKNOWN;
            r_valid     <= 1'b0;
        end else if (i_fire) begin
            r_countdown <= n_countdown;
            r_cand      <= n_cand;
            r_count     <= n_count;
            r_stable    <= n_stable;
            r_valid     <= n_valid;
        end
    end

endmodule

>>> rtl/button_debounce_head_id_qualifier.sv
// top level: config registers, debouncer lanes, head qualifier and output merge with skid
// result: an accepted tick item's result is registered into the output slot or the skid entry
// throughput: one tick item per cycle while ready; every lane and the head update on accept
// output: a result register plus one skid entry, so input ready only drops while both are full
// reset: synchronous active low; buttons read released, ages and sample timer clear so the
// first tick takes a head sample, head unknown and unconfirmed, registers take default values
module button_debounce_head_id_qualifier (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // tick items
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [bdhq_pkg::BTN_OUT_W-1:0]    i_in_raw_buttons,
    input  logic [bdhq_pkg::ADC_BITS-1:0]     i_in_head_adc,
    // result items
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [bdhq_pkg::BTN_OUT_W-1:0]    o_out_stable_buttons,
    output logic [bdhq_pkg::BTN_OUT_W-1:0]    o_out_button_changed,
    output logic [1:0]                        o_out_head_type,
    output logic                              o_out_head_known,
    output logic                              o_out_head_changed,
    output logic                              o_out_head_sampled,
    // register writes
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [bdhq_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [bdhq_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    // configuration registers
    logic [bdhq_pkg::TICK_W-1:0] r_debounce;
    bdhq_pkg::t_head_cfg         r_head_cfg;

    logic                        w_fire;
    logic [bdhq_pkg::BUTTONS-1:0] w_lane_stable;
    logic [bdhq_pkg::BUTTONS-1:0] w_lane_changed;
    bdhq_pkg::t_head_res         w_head;
    bdhq_pkg::t_result           w_result;

    // output register and skid entry
    bdhq_pkg::t_result           r_out;
    logic                        r_out_valid;
    bdhq_pkg::t_result           r_skid;
    logic                        r_skid_valid;
    logic                        w_out_take;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = !r_skid_valid;
    assign w_fire      = i_in_valid && o_in_ready;
    assign w_out_take  = r_out_valid && i_out_ready;

    // register writes, index beyond the map is dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce                 <= bdhq_pkg::RST_DEBOUNCE;
            r_head_cfg.sample_interval <= bdhq_pkg::RST_SAMPLE_IVL;
            r_head_cfg.tracer_low      <= bdhq_pkg::RST_TRACER_LOW;
            r_head_cfg.tracer_high     <= bdhq_pkg::RST_TRACER_HIGH;
            r_head_cfg.cutter_low      <= bdhq_pkg::RST_CUTTER_LOW;
            r_head_cfg.cutter_high     <= bdhq_pkg::RST_CUTTER_HIGH;
            r_head_cfg.absent_low      <= bdhq_pkg::RST_ABSENT_LOW;
            r_head_cfg.assume_cutter   <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                bdhq_pkg::CFG_DEBOUNCE: begin
                    r_debounce <= i_cfg_data[bdhq_pkg::TICK_W-1:0];
                end
                bdhq_pkg::CFG_SAMPLE_IVL: begin
                    r_head_cfg.sample_interval <= i_cfg_data[bdhq_pkg::TICK_W-1:0];
                end
                bdhq_pkg::CFG_TRACER_LOW: begin
                    r_head_cfg.tracer_low <= i_cfg_data[bdhq_pkg::ADC_BITS-1:0];
                end
                bdhq_pkg::CFG_TRACER_HIGH: begin
                    r_head_cfg.tracer_high <= i_cfg_data[bdhq_pkg::ADC_BITS-1:0];
                end
                bdhq_pkg::CFG_CUTTER_LOW: begin
                    r_head_cfg.cutter_low <= i_cfg_data[bdhq_pkg::ADC_BITS-1:0];
                end
                bdhq_pkg::CFG_CUTTER_HIGH: begin
                    r_head_cfg.cutter_high <= i_cfg_data[bdhq_pkg::ADC_BITS-1:0];
                end
                bdhq_pkg::CFG_ABSENT_LOW: begin
                    r_head_cfg.absent_low <= i_cfg_data[bdhq_pkg::ADC_BITS-1:0];
                end
                bdhq_pkg::CFG_ASSUME_CUTTER: begin
                    r_head_cfg.assume_cutter <= i_cfg_data[0];
                end
                default: begin
                end
            endcase
        end
    end

    // one debouncer per button, all updated in the accept cycle
    for (genvar g = 0; g < bdhq_pkg::BUTTONS; g++) begin : g_lane
        bdhq_lane u_lane (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_fire     (w_fire),
            .i_raw      (i_in_raw_buttons[g]),
            .i_debounce (r_debounce),
            .o_stable   (w_lane_stable[g]),
            .o_changed  (w_lane_changed[g])
        );
    end

    bdhq_head u_head (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (w_fire),
        .i_adc   (i_in_head_adc),
        .i_cfg   (r_head_cfg),
        .o_res   (w_head)
    );

    // merge lane findings and head result; unused button bits read released and unchanged
    always_comb begin
        w_result.stable_buttons = {bdhq_pkg::BTN_OUT_W{1'b1}};
        w_result.button_changed = '0;
        w_result.stable_buttons[bdhq_pkg::BUTTONS-1:0] = w_lane_stable;
        w_result.button_changed[bdhq_pkg::BUTTONS-1:0] = w_lane_changed;
        w_result.head = w_head;
    end

    // output register with skid: new item goes to the output slot when it is free or
    // being drained with nothing in the skid, otherwise it parks in the skid entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (!r_out_valid || w_out_take) begin
                if (r_skid_valid) begin
                    r_out_valid  <= 1'b1;
                    r_skid_valid <= w_fire;
                end else begin
                    r_out_valid  <= w_fire;
                end
            end else if (w_fire) begin
                r_skid_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || w_out_take) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
                if (w_fire) begin
                    r_skid <= w_result;
                end
            end else if (w_fire) begin
                r_out <= w_result;
            end
        end else if (w_fire) begin
            r_skid <= w_result;
        end
    end

    assign o_out_valid          = r_out_valid;
    assign o_out_stable_buttons = r_out.stable_buttons;
    assign o_out_button_changed = r_out.button_changed;
    assign o_out_head_type      = r_out.head.head_type;
    assign o_out_head_known     = r_out.head.head_known;
    assign o_out_head_changed   = r_out.head.head_changed;
    assign o_out_head_sampled   = r_out.head.head_sampled;

    // skid entry only fills behind a held output slot
    a_skid_behind_out : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry full while output slot empty");

    // an item taken while the output is stalled must land in the skid entry
    a_stall_to_skid : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && r_out_valid && !i_out_ready) |=> r_skid_valid)
        else $error("item accepted under stall was not parked");

    // a head change only happens on a sample tick and always confirms the head
    a_head_change : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_head_changed) |-> (o_out_head_sampled && o_out_head_known))
        else $error("head change without sample or confirmation");

    // a button change must leave the stable level equal to the raw level of that tick
    a_btn_change : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && (w_lane_changed != '0))
            |-> ((w_lane_stable & w_lane_changed)
                 == (i_in_raw_buttons[bdhq_pkg::BUTTONS-1:0] & w_lane_changed)))
        else $error("debounced level did not follow raw level on change");

endmodule
